### sv/odometry_motion_statistics_unit_defines.svh
// assertion macros for the odometry motion statistics unit
`ifndef ODOMETRY_MOTION_STATISTICS_UNIT_DEFINES_SVH
`define ODOMETRY_MOTION_STATISTICS_UNIT_DEFINES_SVH
`ifndef SYNTH
`define OMS_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define OMS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define OMS_ASSERT_IMPL(label, clk, rst_n, prop)
`define OMS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### sv/oms_pkg.sv
`default_nettype none
package oms_pkg;
    localparam int unsigned NUM_REGS = 5;
    localparam logic [2:0] REG_AVG_ALPHA   = 3'd0;
    localparam logic [2:0] REG_ACCEL_ALPHA = 3'd1;
    localparam logic [2:0] REG_JUMP_LIMIT  = 3'd2;
    localparam logic [2:0] REG_DT_MIN      = 3'd3;
    localparam logic [2:0] REG_DT_MAX      = 3'd4;
    localparam logic [63:0] US_PER_S = 64'd1000000;

    typedef struct packed {
        logic [31:0] sample_time_us;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
    } sample_t;

    typedef struct packed {
        logic [31:0] speed_3d;
        logic [31:0] speed_horizontal;
        logic [31:0] speed_average;
        logic [31:0] accel_smoothed;
        logic [47:0] path_length;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SQRT_H, ST_SQRT_3, ST_SQRT_D, ST_SQRT_V,
        ST_MUL, ST_DIV, ST_BLEND_A, ST_BLEND_C, ST_OUT
    } state_t;

    // square root unit control
    typedef struct packed {
        logic        start;
        logic [65:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

### sv/oms_stream_if.sv
`default_nettype none
interface oms_stream_if #(parameter int unsigned W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/oms_sqrt.sv
`default_nettype none
// bit-serial floor square root, one root bit per cycle
module oms_sqrt
    import oms_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire sqrt_req_t req,
    output logic           busy,
    output logic [32:0]    root
);
    logic [65:0] rad_reg, rad_next;
    logic [35:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [35:0] rem_sh, trial;

    always_comb
    begin
        rem_sh   = {rem_reg[33:0], rad_reg[65:64]};
        trial    = {1'b0, root_reg, 2'b01};
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            rad_next  = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd33;
        end
        else if (cnt_reg != 6'd0)
        begin
            rad_next = {rad_reg[63:0], 2'b00};
            cnt_next = cnt_reg - 6'd1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != 6'd0);
    assign root = root_reg;
endmodule
`default_nettype wire

### sv/oms_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module oms_div
    import oms_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output logic          busy,
    output logic [63:0]   quot
);
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] r_sh;

    always_comb
    begin
        r_sh   = {r_reg[31:0], q_reg[63]};
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        if (req.start)
        begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != 7'd0);
    assign quot = q_reg;
endmodule
`default_nettype wire

### sv/odometry_motion_statistics_unit.sv
// result timing is set by the shared bit-serial square root and, when the acceleration
//   updates, the serial divider
// flow: one sample at a time; the next sample is taken once the result beat has left
//   the output register
// reset: rst_n asynchronous active low; registers take their defaults, statistics clear
`default_nettype none
`include "odometry_motion_statistics_unit_defines.svh"
module odometry_motion_statistics_unit
    import oms_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    oms_stream_if.sink   in_if,
    oms_stream_if.source out_if
);
    // configuration registers
    logic [15:0] avg_alpha_reg, accel_alpha_reg;
    logic [31:0] jump_limit_reg, dt_min_reg, dt_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_alpha_reg   <= 16'd1311;
            accel_alpha_reg <= 16'd19661;
            jump_limit_reg  <= 32'd65536;
            dt_min_reg      <= 32'd1000;
            dt_max_reg      <= 32'd1000000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AVG_ALPHA:   avg_alpha_reg   <= cfg_data[15:0];
                REG_ACCEL_ALPHA: accel_alpha_reg <= cfg_data[15:0];
                REG_JUMP_LIMIT:  jump_limit_reg  <= cfg_data;
                REG_DT_MIN:      dt_min_reg      <= cfg_data;
                REG_DT_MAX:      dt_max_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // statistics state
    logic        seen_reg, seen_next;
    logic [31:0] prev_time_reg, prev_time_next;
    logic [31:0] pvx_reg, pvy_reg, pvz_reg;
    logic [31:0] lpx_reg, lpy_reg, lpz_reg;
    logic [31:0] avg_reg, avg_next;
    logic [31:0] acc_reg, acc_next;
    logic [47:0] path_reg, path_next;

    // working registers
    sample_t     smp_reg, smp_next;
    state_t      st_reg, st_next;
    logic [1:0]  sq_cnt_reg, sq_cnt_next;
    logic [65:0] sumh_reg, sumh_next;   // vx^2+vy^2
    logic [65:0] sum3_reg, sum3_next;   // plus vz^2
    logic [65:0] sumd_reg, sumd_next;   // position step
    logic [65:0] sumv_reg, sumv_next;   // velocity change
    logic [31:0] sh_reg, sh_next, s3_reg, s3_next;
    logic [32:0] dist_reg, dist_next;
    logic [32:0] dmag_reg, dmag_next;
    logic [63:0] prod_reg, prod_next;
    logic        acc_ok_reg, acc_ok_next;
    logic        launched_reg, launched_next;
    result_t     res_reg, res_next;
    logic        ovalid_reg, ovalid_next;

    sqrt_req_t sq_req;
    div_req_t  dv_req;
    logic      sq_busy, dv_busy;
    logic [32:0] sq_root;
    logic [63:0] dv_quot;

    oms_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .busy(sq_busy), .root(sq_root));
    oms_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dv_req), .busy(dv_busy), .quot(dv_quot));

    // one component per cycle of each of the three squares, each through its own 33x33 multiplier
    logic [32:0] ma, a_sel, b_sel;
    logic [65:0] sq_val;
    logic signed [32:0] dv0, dv1, dv2, dp0, dp1, dp2, sel_v, sel_dv, sel_dp;

    function automatic logic [32:0] abs33(input logic signed [32:0] x);
        abs33 = x[32] ? 33'(-x) : 33'(x);
    endfunction

    // blend: (a*x + (65536-a)*old + 32768) >> 16, saturate to 32 bits
    logic [15:0] bl_a;
    logic [31:0] bl_x, bl_old;
    logic [16:0] bl_na;
    logic [48:0] bl_sum;
    logic [31:0] bl_res;
    logic [31:0] dt;
    logic        in_window;

    always_comb
    begin
        dv0 = $signed({smp_reg.vel_x[31], smp_reg.vel_x}) - $signed({pvx_reg[31], pvx_reg});
        dv1 = $signed({smp_reg.vel_y[31], smp_reg.vel_y}) - $signed({pvy_reg[31], pvy_reg});
        dv2 = $signed({smp_reg.vel_z[31], smp_reg.vel_z}) - $signed({pvz_reg[31], pvz_reg});
        dp0 = $signed({smp_reg.pos_x[31], smp_reg.pos_x}) - $signed({lpx_reg[31], lpx_reg});
        dp1 = $signed({smp_reg.pos_y[31], smp_reg.pos_y}) - $signed({lpy_reg[31], lpy_reg});
        dp2 = $signed({smp_reg.pos_z[31], smp_reg.pos_z}) - $signed({lpz_reg[31], lpz_reg});
        case (sq_cnt_reg)
            2'd0:    begin sel_v = $signed({smp_reg.vel_x[31], smp_reg.vel_x});
                           sel_dv = dv0; sel_dp = dp0; end
            2'd1:    begin sel_v = $signed({smp_reg.vel_y[31], smp_reg.vel_y});
                           sel_dv = dv1; sel_dp = dp1; end
            default: begin sel_v = $signed({smp_reg.vel_z[31], smp_reg.vel_z});
                           sel_dv = dv2; sel_dp = dp2; end
        endcase
        a_sel = abs33(sel_v);
        b_sel = abs33(sel_dp);
        ma    = abs33(sel_dv);
        sq_val = a_sel * a_sel;
    end

    // the sq counter selects the x, y or z component for all three squares at once;
    // velocity, step and dv squares each have their own multiplier
    logic [65:0] sq_dp, sq_dv;
    assign sq_dp = b_sel * b_sel;
    assign sq_dv = ma * ma;

    assign dt        = smp_reg.sample_time_us - prev_time_reg;
    assign in_window = (dt > dt_min_reg) && (dt < dt_max_reg);

    always_comb
    begin
        bl_a   = (st_reg == ST_BLEND_A) ? avg_alpha_reg : accel_alpha_reg;
        bl_x   = (st_reg == ST_BLEND_A) ? sh_reg : ((dv_quot[63:32] != 32'd0) ? 32'hFFFF_FFFF
                                                   : dv_quot[31:0]);
        bl_old = (st_reg == ST_BLEND_A) ? avg_reg : acc_reg;
        bl_na  = 17'h10000 - {1'b0, bl_a};
        bl_sum = {33'd0, bl_a} * {17'd0, bl_x} + {32'd0, bl_na} * {17'd0, bl_old}
               + 49'd32768;
        if (bl_sum[48] != 1'b0)
            bl_res = 32'hFFFF_FFFF;
        else
            bl_res = bl_sum[47:16];
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:    if (in_if.valid && !ovalid_reg) st_next = ST_SQ;
            ST_SQ:      if (sq_cnt_reg == 2'd2) st_next = ST_SQRT_H;
            ST_SQRT_H:  if (launched_reg && !sq_busy) st_next = ST_SQRT_3;
            ST_SQRT_3:  if (launched_reg && !sq_busy)
                            st_next = seen_reg ? ST_SQRT_D : ST_OUT;
            ST_SQRT_D:  if (launched_reg && !sq_busy)
                            st_next = acc_ok_reg ? ST_SQRT_V : ST_BLEND_A;
            ST_SQRT_V:  if (launched_reg && !sq_busy) st_next = ST_MUL;
            ST_MUL:     st_next = ST_DIV;
            ST_DIV:     if (launched_reg && !dv_busy) st_next = ST_BLEND_C;
            ST_BLEND_C: st_next = ST_BLEND_A;
            ST_BLEND_A: st_next = ST_OUT;
            ST_OUT:     st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        smp_next = smp_reg;
        sq_cnt_next = sq_cnt_reg;
        sumh_next = sumh_reg; sum3_next = sum3_reg;
        sumd_next = sumd_reg; sumv_next = sumv_reg;
        sh_next = sh_reg; s3_next = s3_reg;
        dist_next = dist_reg; dmag_next = dmag_reg;
        prod_next = prod_reg;
        acc_ok_next = acc_ok_reg;
        launched_next = 1'b0;
        seen_next = seen_reg; prev_time_next = prev_time_reg;
        avg_next = avg_reg; acc_next = acc_reg; path_next = path_reg;
        res_next = res_reg;
        ovalid_next = ovalid_reg;
        sq_req.start = 1'b0; sq_req.radicand = sumh_reg;
        dv_req.start = 1'b0; dv_req.dividend = prod_reg; dv_req.divisor = dt;
        if (out_if.ready)
            ovalid_next = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                sq_cnt_next = 2'd0;
                sumh_next = '0; sum3_next = '0; sumd_next = '0; sumv_next = '0;
                if (in_if.valid && !ovalid_reg)
                    smp_next = in_if.payload;
            end
            ST_SQ:
            begin
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg != 2'd2)
                    sumh_next = sumh_reg + sq_val;
                sum3_next = sum3_reg + sq_val;
                sumd_next = sumd_reg + sq_dp;
                sumv_next = sumv_reg + sq_dv;
                acc_ok_next = in_window;
            end
            ST_SQRT_H, ST_SQRT_3, ST_SQRT_D, ST_SQRT_V:
            begin
                launched_next = 1'b1;
                if (!launched_reg)
                begin
                    sq_req.start = 1'b1;
                    case (st_reg)
                        ST_SQRT_H: sq_req.radicand = sumh_reg;
                        ST_SQRT_3: sq_req.radicand = sum3_reg;
                        ST_SQRT_D: sq_req.radicand = sumd_reg;
                        default:   sq_req.radicand = sumv_reg;
                    endcase
                end
                else if (!sq_busy)
                begin
                    launched_next = 1'b0;
                    case (st_reg)
                        ST_SQRT_H: sh_next = sq_root[31:0];
                        ST_SQRT_3: s3_next = sq_root[31:0];
                        ST_SQRT_D: dist_next = sq_root;
                        default:   dmag_next = sq_root;
                    endcase
                end
            end
            ST_MUL:
                prod_next = {31'd0, dmag_reg} * 64'd1000000;
            ST_DIV:
            begin
                launched_next = 1'b1;
                if (!launched_reg)
                    dv_req.start = 1'b1;
                else if (!dv_busy)
                    launched_next = 1'b0;
            end
            ST_BLEND_C:
                acc_next = bl_res;
            ST_BLEND_A:
            begin
                avg_next = bl_res;
                if (dist_reg < {1'b0, jump_limit_reg})
                    path_next = (49'(path_reg) + 49'(dist_reg) > 49'h0_FFFF_FFFF_FFFF)
                              ? 48'hFFFF_FFFF_FFFF : 48'(path_reg + 48'(dist_reg));
            end
            ST_OUT:
            begin
                if (!seen_reg)
                    avg_next = sh_reg;
                seen_next = 1'b1;
                prev_time_next = smp_reg.sample_time_us;
                res_next.speed_3d = s3_reg;
                res_next.speed_horizontal = sh_reg;
                res_next.speed_average = seen_reg ? avg_reg : sh_reg;
                res_next.accel_smoothed = acc_reg;
                res_next.path_length = path_reg;
                ovalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            sq_cnt_reg <= '0;
            launched_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            seen_reg <= 1'b0;
            prev_time_reg <= '0;
            pvx_reg <= '0; pvy_reg <= '0; pvz_reg <= '0;
            lpx_reg <= '0; lpy_reg <= '0; lpz_reg <= '0;
            avg_reg <= '0; acc_reg <= '0; path_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            sq_cnt_reg <= sq_cnt_next;
            launched_reg <= launched_next;
            ovalid_reg <= ovalid_next;
            seen_reg <= seen_next;
            prev_time_reg <= prev_time_next;
            avg_reg <= avg_next; acc_reg <= acc_next; path_reg <= path_next;
            if (st_reg == ST_OUT)
            begin
                pvx_reg <= smp_reg.vel_x; pvy_reg <= smp_reg.vel_y; pvz_reg <= smp_reg.vel_z;
                lpx_reg <= smp_reg.pos_x; lpy_reg <= smp_reg.pos_y; lpz_reg <= smp_reg.pos_z;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        sumh_reg <= sumh_next; sum3_reg <= sum3_next;
        sumd_reg <= sumd_next; sumv_reg <= sumv_next;
        sh_reg <= sh_next; s3_reg <= s3_next;
        dist_reg <= dist_next; dmag_reg <= dmag_next;
        prod_reg <= prod_next;
        acc_ok_reg <= acc_ok_next;
        res_reg <= res_next;
    end

    // handshake: take a sample only when idle and the output register is free
    assign in_if.ready    = (st_reg == ST_IDLE) && !ovalid_reg;
    assign out_if.valid   = ovalid_reg;
    assign out_if.payload = res_reg;

    `OMS_ASSERT_IMPL(a_out_only_after_done, clk, rst_n,
        $rose(ovalid_reg) |-> $past(st_reg == ST_OUT))
    `OMS_ASSERT_NEVER(a_no_accept_busy, clk, rst_n, in_if.valid && in_if.ready && ovalid_reg)
    `OMS_ASSERT_NEVER(a_path_monotone, clk, rst_n, path_reg < $past(path_reg))
endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;
    import oms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_WAIT = 300;
    localparam int unsigned ITEMS_PER_PHASE = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    oms_stream_if #(.W($bits(sample_t))) in_ch ();
    oms_stream_if #(.W($bits(result_t))) out_ch ();

    odometry_motion_statistics_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_if(in_ch.sink),
        .out_if(out_ch.source)
    );

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // motion model: own copy of registers and statistics state
    // ------------------------------------------------------------------
    logic [15:0] m_avg_alpha;
    logic [15:0] m_accel_alpha;
    logic [31:0] m_jump_limit;
    logic [31:0] m_dt_min;
    logic [31:0] m_dt_max;

    logic        m_seen_first;
    logic [31:0] m_prev_time;
    logic [31:0] m_prev_vel [3];
    logic [31:0] m_last_pos [3];
    logic [31:0] m_avg_speed;
    logic [31:0] m_accel;
    logic [47:0] m_path;

    // results still owed by the block, oldest first
    result_t motion_results_q [$];
    // per sent sample: a typed-in result to use instead of the model's, if any
    logic    fixed_valid_q [$];
    result_t fixed_result_q [$];

    int unsigned fail_count;
    int unsigned cycle_count;
    bit          calm;     // no stalls on either side while set

    // floor square root of a value below 2^66, restoring bit-pair method
    function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [32:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | ((v >> (2 * i)) & 66'd3);
            trial = ({35'd0, root} << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 33'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic logic [65:0] sq_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic [32:0] m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? -d : d;
        return {33'd0, m} * {33'd0, m};
    endfunction

    // first-order low-pass in q0.16 weight, rounding half up, clamped to 32 bits
    function automatic logic [31:0] lowpass(input logic [15:0] a, input logic [63:0] x,
                                            input logic [31:0] old);
        logic [63:0] r;
        r = ({48'd0, a} * x + (64'd65536 - {48'd0, a}) * {32'd0, old} + 64'd32768) >> 16;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic result_t motion_step(input sample_t s);
        result_t     r;
        logic [31:0] pos [3];
        logic [31:0] vel [3];
        logic [65:0] acc;
        logic [32:0] sh;
        logic [32:0] s3;
        logic [32:0] step_len;
        logic [32:0] dmag;
        logic [31:0] dt;
        logic [63:0] raw;
        logic [48:0] sum;
        pos[0] = s.pos_x; pos[1] = s.pos_y; pos[2] = s.pos_z;
        vel[0] = s.vel_x; vel[1] = s.vel_y; vel[2] = s.vel_z;
        acc = sq_diff(vel[0], 32'd0) + sq_diff(vel[1], 32'd0);
        sh = floor_sqrt(acc);
        s3 = floor_sqrt(acc + sq_diff(vel[2], 32'd0));
        if (!m_seen_first)
            m_avg_speed = sh[31:0];
        else
        begin
            m_avg_speed = lowpass(m_avg_alpha, {31'd0, sh}, m_avg_speed);
            acc = '0;
            for (int k = 0; k < 3; k++)
                acc = acc + sq_diff(pos[k], m_last_pos[k]);
            step_len = floor_sqrt(acc);
            if (step_len < {1'b0, m_jump_limit})
            begin
                sum = {1'b0, m_path} + {16'd0, step_len};
                m_path = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
            end
            dt = s.sample_time_us - m_prev_time;
            if (dt > m_dt_min && dt < m_dt_max)
            begin
                acc = '0;
                for (int k = 0; k < 3; k++)
                    acc = acc + sq_diff(vel[k], m_prev_vel[k]);
                dmag = floor_sqrt(acc);
                raw = ({31'd0, dmag} * US_PER_S) / {32'd0, dt};
                if (raw > 64'hFFFF_FFFF)
                    raw = 64'hFFFF_FFFF;
                m_accel = lowpass(m_accel_alpha, raw, m_accel);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            m_last_pos[k] = pos[k];
            m_prev_vel[k] = vel[k];
        end
        m_seen_first = 1'b1;
        m_prev_time = s.sample_time_us;
        r.speed_3d = s3[31:0];
        r.speed_horizontal = sh[31:0];
        r.speed_average = m_avg_speed;
        r.accel_smoothed = m_accel;
        r.path_length = m_path;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side: model runs on every accepted sample beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t predicted;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predicted = motion_step(sample_t'(in_ch.payload));
            // a typed-in row overrides the model; the model still advances
            if (fixed_valid_q.size() != 0 && fixed_valid_q.pop_front())
                predicted = fixed_result_q.pop_front();
            else if (fixed_result_q.size() != 0)
                void'(fixed_result_q.pop_front());
            motion_results_q.push_back(predicted);
        end
    end

    // ------------------------------------------------------------------
    // output side: random back-pressure and field-by-field compare
    // ------------------------------------------------------------------
    int unsigned stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        logic next_ready;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = result_t'(out_ch.payload);
                if (motion_results_q.size() == 0)
                begin
                    $display("%0t result beat with nothing expected: %h", $realtime, got);
                    fail_count++;
                end
                else
                begin
                    want = motion_results_q.pop_front();
                    if (got.speed_3d !== want.speed_3d)
                    begin
                        $display("%0t speed_3d expected %h actual %h",
                                 $realtime, want.speed_3d, got.speed_3d);
                        fail_count++;
                    end
                    if (got.speed_horizontal !== want.speed_horizontal)
                    begin
                        $display("%0t speed_horizontal expected %h actual %h",
                                 $realtime, want.speed_horizontal, got.speed_horizontal);
                        fail_count++;
                    end
                    if (got.speed_average !== want.speed_average)
                    begin
                        $display("%0t speed_average expected %h actual %h",
                                 $realtime, want.speed_average, got.speed_average);
                        fail_count++;
                    end
                    if (got.accel_smoothed !== want.accel_smoothed)
                    begin
                        $display("%0t accel_smoothed expected %h actual %h",
                                 $realtime, want.accel_smoothed, got.accel_smoothed);
                        fail_count++;
                    end
                    if (got.path_length !== want.path_length)
                    begin
                        $display("%0t path_length expected %h actual %h",
                                 $realtime, want.path_length, got.path_length);
                        fail_count++;
                    end
                end
                // fresh stall for the next result beat
                stall_left = calm ? 0 : $urandom_range(0, 17);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            out_ch.ready <= next_ready;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_sample(input sample_t s, input bit has_fixed, input result_t fixed);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fixed_valid_q.push_back(has_fixed);
        fixed_result_q.push_back(fixed);
        in_ch.valid <= 1'b1;
        in_ch.payload <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // idle the sender until every owed result is back, then let the block settle
    task automatic drain;
        in_ch.valid <= 1'b0;
        while (motion_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] avg_a, input logic [15:0] acc_a,
                                input logic [31:0] jump, input logic [31:0] dmin,
                                input logic [31:0] dmax);
        logic [31:0] vals [NUM_REGS];
        logic [2:0]  idx  [NUM_REGS];
        drain();
        vals[0] = {16'd0, avg_a}; idx[0] = REG_AVG_ALPHA;
        vals[1] = {16'd0, acc_a}; idx[1] = REG_ACCEL_ALPHA;
        vals[2] = jump;           idx[2] = REG_JUMP_LIMIT;
        vals[3] = dmin;           idx[3] = REG_DT_MIN;
        vals[4] = dmax;           idx[4] = REG_DT_MAX;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        m_avg_alpha = avg_a;
        m_accel_alpha = acc_a;
        m_jump_limit = jump;
        m_dt_min = dmin;
        m_dt_max = dmax;
    endtask

    function automatic sample_t mk(input logic [31:0] t, input logic [31:0] px,
                                   input logic [31:0] py, input logic [31:0] pz,
                                   input logic [31:0] vx, input logic [31:0] vy,
                                   input logic [31:0] vz);
        sample_t s;
        s.sample_time_us = t;
        s.pos_x = px; s.pos_y = py; s.pos_z = pz;
        s.vel_x = vx; s.vel_y = vy; s.vel_z = vz;
        return s;
    endfunction

    function automatic logic [31:0] wander(input logic [31:0] v);
        return v + 32'($signed($urandom_range(0, 2 * 40000)) - 40000);
    endfunction

    // trajectory walker: mostly plausible motion, some wild beats
    sample_t walk;

    function automatic sample_t next_motion();
        sample_t s;
        int unsigned pick;
        s = walk;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            if (pick < 80 && m_dt_max > m_dt_min + 2)
                s.sample_time_us = s.sample_time_us + m_dt_min + 1 +
                    $urandom_range(0, ((m_dt_max - m_dt_min - 2) > 200000) ?
                                   200000 : (m_dt_max - m_dt_min - 2));
            else if (pick < 85)
                s.sample_time_us = s.sample_time_us - $urandom_range(0, 100);
            else
                s.sample_time_us = s.sample_time_us + $urandom_range(0, 3000);
            s.pos_x = wander(s.pos_x);
            s.pos_y = wander(s.pos_y);
            s.pos_z = (pick < 88) ? s.pos_z + $urandom_range(0, 200000) : wander(s.pos_z);
            s.vel_x = wander(s.vel_x);
            s.vel_y = wander(s.vel_y);
            s.vel_z = wander(s.vel_z);
        end
        return s;
    endfunction

    task automatic motion_phase(input int unsigned count);
        result_t none;
        none = '0;
        for (int unsigned i = 0; i < count; i++)
        begin
            // some stretches run with no stalls at all
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            walk = next_motion();
            send_sample(walk, 1'b0, none);
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // directed table: first sample after reset, extremes, interval edges
    // ------------------------------------------------------------------
    typedef struct {
        sample_t s;
        bit      has_fixed;
        result_t fixed;
    } stim_row_t;

    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    stim_row_t steer [$];

    initial
    begin
        stim_row_t row;
        result_t none;
        none = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        fail_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        walk = '0;
        // reset defaults of the registers and cleared statistics
        m_avg_alpha = 16'd1311;
        m_accel_alpha = 16'd19661;
        m_jump_limit = ONE;
        m_dt_min = 32'd1000;
        m_dt_max = 32'd1000000;
        m_seen_first = 1'b0;
        m_prev_time = '0;
        m_avg_speed = '0;
        m_accel = '0;
        m_path = '0;
        for (int k = 0; k < 3; k++)
        begin
            m_prev_vel[k] = '0;
            m_last_pos[k] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample: velocity 3,4,12 m/s gives 13 and 5, average seeded, no travel
        row.s = mk(32'd0, 32'd0, 32'd0, 32'd0, 3 * ONE, 4 * ONE, 12 * ONE);
        row.has_fixed = 1'b1;
        row.fixed = '{speed_3d: 13 * ONE, speed_horizontal: 5 * ONE,
                      speed_average: 5 * ONE, accel_smoothed: 32'd0, path_length: 48'd0};
        steer.push_back(row);
        row.has_fixed = 1'b0;
        row.fixed = none;
        // small step inside the jump limit, dt well inside the window
        row.s = mk(32'd20000, ONE / 2, 32'd0, 32'd0, 3 * ONE, 4 * ONE, 12 * ONE);
        steer.push_back(row);
        // step far beyond the jump limit
        row.s = mk(32'd40000, SMAX, SMIN, SMAX, SMAX, SMAX, SMAX);
        steer.push_back(row);
        row.s = mk(32'd60000, SMIN, SMAX, SMIN, SMIN, SMIN, SMIN);
        steer.push_back(row);
        row.s = mk(32'd80000, 32'hFFFF_FFFF, 32'd0, 32'd1, SMIN, SMAX, 32'd0);
        steer.push_back(row);
        // step exactly at the jump limit is not counted, just under it is
        row.s = mk(32'd100000, 32'hFFFF_FFFF + ONE, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
        steer.push_back(row);
        row.s = mk(32'd120000, 32'hFFFF_FFFF + 2 * ONE - 1, 32'd0, 32'd1, ONE, 0, 0);
        steer.push_back(row);
        // dt exactly at the lower bound, then one above
        row.s = mk(32'd121000, 32'd0, 32'd0, 32'd0, 9 * ONE, 0, 0);
        steer.push_back(row);
        row.s = mk(32'd122001, 32'd0, 32'd0, 32'd0, 0, 9 * ONE, 0);
        steer.push_back(row);
        // dt exactly at the upper bound, then one below
        row.s = mk(32'd1122001, 32'd0, 32'd0, 32'd0, 0, 0, 9 * ONE);
        steer.push_back(row);
        row.s = mk(32'd2122000, 32'd0, 32'd0, 32'd0, SMAX, 0, 0);
        steer.push_back(row);
        // timestamp going back wraps to a huge interval
        row.s = mk(32'd2000000, 32'd5, 32'd6, 32'd7, 0, SMIN, 0);
        steer.push_back(row);
        // timestamp wrap through 2^32 with a legal interval
        row.s = mk(32'hFFFF_FF00, 32'd5, 32'd6, 32'd7, 0, 0, 0);
        steer.push_back(row);
        row.s = mk(32'd5000, 32'd5, 32'd6, 32'd7, SMIN, SMIN, SMIN);
        steer.push_back(row);
        // same timestamp: zero interval
        row.s = mk(32'd5000, 32'd5, 32'd6, 32'd7, SMAX, SMAX, SMAX);
        steer.push_back(row);
        // largest velocity change over the shortest legal interval saturates
        row.s = mk(32'd6001, 32'd5, 32'd6, 32'd7, SMIN, SMIN, SMIN);
        steer.push_back(row);

        foreach (steer[i])
            send_sample(steer[i].s, steer[i].has_fixed, steer[i].fixed);

        // hold off the sender until the block has caught up
        drain();

        motion_phase(ITEMS_PER_PHASE);

        // extremes: average frozen, acceleration follows raw, every step below 2^32 - 1 counted,
        // widest interval window
        program_regs(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        motion_phase(ITEMS_PER_PHASE);

        // opposite extremes: empty interval window, no step counted
        program_regs(16'hFFFF, 16'd0, 32'd0, 32'd5, 32'd6);
        motion_phase(ITEMS_PER_PHASE / 2);
        program_regs(16'd100, 16'd200, 32'd100, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        motion_phase(ITEMS_PER_PHASE / 4);

        // random settings
        for (int p = 0; p < 3; p++)
        begin
            logic [31:0] lo_dt;
            lo_dt = $urandom_range(0, 5000);
            program_regs(16'($urandom), 16'($urandom), $urandom_range(0, 32'h0100_0000),
                         lo_dt, lo_dt + $urandom_range(0, 400000));
            motion_phase(ITEMS_PER_PHASE / 2);
        end

        // back to the reset values
        program_regs(16'd1311, 16'd19661, ONE, 32'd1000, 32'd1000000);
        motion_phase(ITEMS_PER_PHASE / 2);

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
